// ===== src/wrm_pkg.sv =====
// ---------------------------------------------------------------------------
// wrm_pkg: shared types and constants of the windowed rate meter
// Field widths, mode codes and the queue entry carried from front to back.
// ---------------------------------------------------------------------------
package wrm_pkg;

  localparam int DEF_CHANNELS   = 8;
  localparam int DEF_RING_DEPTH = 16;

  localparam int MODE_W  = 2;
  localparam int CHAN_W  = 3;
  localparam int COUNT_W = 64;
  localparam int STAMP_W = 48;
  localparam int WIN_W   = 32;
  localparam int RATE_W  = 64;

  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RATE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TOTAL  = 2'd2;
  // Unused code; such beats are taken and dropped.
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd3;

  // Milliseconds to seconds times 2^16.
  localparam logic [26:0] MS_Q16 = 27'd65536000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAN_W-1:0]  channel;
    logic [COUNT_W-1:0] sample_count;
    logic [STAMP_W-1:0] time_ms;
    logic [WIN_W-1:0]   window_ms;
  } cmd_t;

endpackage

// ===== src/wrm_in_if.sv =====
// ---------------------------------------------------------------------------
// wrm_in_if: input channel of the rate meter
// Valid/ready channel carrying one command beat.
// ---------------------------------------------------------------------------
interface wrm_in_if;
  import wrm_pkg::*;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [CHAN_W-1:0]  channel;
  logic [COUNT_W-1:0] sample_count;
  logic [STAMP_W-1:0] time_ms;
  logic [WIN_W-1:0]   window_ms;
  modport source (output valid, mode, channel, sample_count, time_ms, window_ms,
                  input ready);
  modport sink (input valid, mode, channel, sample_count, time_ms, window_ms,
                output ready);
endinterface

// ===== src/wrm_out_if.sv =====
// ---------------------------------------------------------------------------
// wrm_out_if: result channel of the rate meter
// Valid/ready channel carrying one result beat.
// ---------------------------------------------------------------------------
interface wrm_out_if;
  import wrm_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_q16;
  logic              rate_valid;
  logic [RATE_W-1:0] highest_q16;
  modport source (output valid, rate_q16, rate_valid, highest_q16, input ready);
  modport sink (input valid, rate_q16, rate_valid, highest_q16, output ready);
endinterface

// ===== src/wrm_ram.sv =====
// ---------------------------------------------------------------------------
// wrm_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module wrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== src/wrm_front.sv =====
// ---------------------------------------------------------------------------
// wrm_front: command intake
// Accepts command beats, drops mode 3, and queues the rest in a small FIFO.
// ---------------------------------------------------------------------------
module wrm_front
  import wrm_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  wrm_in_if.sink in_ch,
  output logic q_valid,
  input  logic q_pop,
  output cmd_t q_head
);
  localparam int QW = $clog2(QDEPTH);

  cmd_t         slots [QDEPTH];
  logic [QW-1:0] rd_ptr, wr_ptr;
  logic [QW:0]   fill;
  logic          push;
  cmd_t          cmd;

  assign cmd = '{mode: in_ch.mode, channel: in_ch.channel,
                 sample_count: in_ch.sample_count, time_ms: in_ch.time_ms,
                 window_ms: in_ch.window_ms};
  assign in_ch.ready = (fill != (QW+1)'(QDEPTH));
  assign push = in_ch.valid && in_ch.ready && (in_ch.mode != MODE_IDLE);
  assign q_valid = (fill != '0);
  assign q_head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (QW+1)'(push) - (QW+1)'(q_pop);
    end
    if (push) begin
      slots[wr_ptr] <= cmd;
    end
  end
endmodule

// ===== src/wrm_back.sv =====
// ---------------------------------------------------------------------------
// wrm_back: sample store, ring walk, divider and total accumulator
// Runs one command at a time from the queue through a sequencer.
// ---------------------------------------------------------------------------
module wrm_back
  import wrm_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  cmd_t q_head,
  wrm_out_if.source out_ch
);
  localparam int RW = $clog2(RING_DEPTH);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW = CW + RW;
  localparam int DEPTH = CHANNELS * RING_DEPTH;
  localparam int DW = COUNT_W + STAMP_W;
  localparam int SCW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHAN  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_WAIT  = 4'd4;
  localparam logic [3:0] S_EXAM  = 4'd5;
  localparam logic [3:0] S_MUL0  = 4'd6;
  localparam logic [3:0] S_MUL1  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_ACC   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]        state;
  cmd_t              cmd;
  logic [SCW-1:0]    clr_addr;
  logic [RW-1:0]     wp [CHANNELS];
  logic [CW-1:0]     ch;
  logic [RW-1:0]     idx;
  logic [RW:0]       step;
  logic              have_new, have_old, full;
  logic [COUNT_W-1:0] new_count, old_count;
  logic [STAMP_W-1:0] new_stamp, old_stamp;
  logic [COUNT_W-1:0] delta;
  logic [63:0]       p0, p1;
  logic [127:0]      dividend;
  logic [STAMP_W:0]  rem;
  logic [63:0]       quot;
  logic [6:0]        bitn;
  logic [STAMP_W-1:0] span;
  logic [RATE_W-1:0] total, highest, rate_r;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [DW-1:0]     ram_wdata, ram_rdata;
  logic [STAMP_W-1:0] rd_stamp, age;
  logic [COUNT_W-1:0] rd_count;
  logic [STAMP_W:0]  trial;
  logic [RATE_W:0]   sum;
  logic              in_range;
  logic [CW-1:0]     cmd_ch;

  assign cmd_ch = CW'(q_head.channel);
  assign in_range = ({{(32-CHAN_W){1'b0}}, cmd.channel} < 32'(CHANNELS));
  assign rd_count = ram_rdata[DW-1:STAMP_W];
  assign rd_stamp = ram_rdata[STAMP_W-1:0];
  assign age = cmd.time_ms - rd_stamp;
  assign delta = new_count - old_count;
  assign trial = {rem[STAMP_W-1:0], dividend[127]} - {1'b0, span};
  assign sum = {1'b0, total} + {1'b0, rate_r};

  wrm_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {ch, idx};
    ram_wdata = {cmd.sample_count, cmd.time_ms};
    q_pop     = 1'b0;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_addr[AW-1:0];
      ram_wdata = '0;
    end else if (state == S_IDLE && q_valid) begin
      q_pop = 1'b1;
      if (q_head.mode == MODE_RECORD &&
          {{(32-CHAN_W){1'b0}}, q_head.channel} < 32'(CHANNELS)) begin
        ram_we    = 1'b1;
        ram_addr  = {cmd_ch, wp[cmd_ch]};
        ram_wdata = {q_head.sample_count, q_head.time_ms};
      end
    end
  end

  assign out_ch.valid       = (state == S_OUT);
  assign out_ch.rate_q16    = rate_r;
  assign out_ch.rate_valid  = (rate_r != '0);
  assign out_ch.highest_q16 = highest;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      highest  <= '0;
      for (int c = 0; c < CHANNELS; c++) wp[c] <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SCW'((1 << AW) - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_head;
            if (q_head.mode == MODE_RECORD) begin
              if ({{(32-CHAN_W){1'b0}}, q_head.channel} < 32'(CHANNELS))
                wp[cmd_ch] <= (wp[cmd_ch] == RW'(RING_DEPTH - 1)) ? '0
                                                                 : wp[cmd_ch] + 1'b1;
            end else begin
              total <= '0;
              ch    <= (q_head.mode == MODE_TOTAL) ? '0 : cmd_ch;
              state <= S_CHAN;
            end
          end
        end
        S_CHAN: begin
          have_new <= 1'b0;
          have_old <= 1'b0;
          full     <= 1'b0;
          step     <= (RW+1)'(1);
          idx      <= (wp[ch] == '0) ? RW'(RING_DEPTH - 1) : wp[ch] - 1'b1;
          rate_r   <= '0;
          if (cmd.mode == MODE_RATE && !in_range) state <= S_ACC;
          else state <= S_RD;
        end
        S_RD: state <= S_WAIT;
        S_WAIT: state <= S_EXAM;
        S_EXAM: begin
          if (rd_stamp == '0) begin
            state <= S_MUL0;
          end else begin
            if (!have_new) begin
              have_new  <= 1'b1;
              new_stamp <= rd_stamp;
              new_count <= rd_count;
            end
            if (age > {{(STAMP_W-WIN_W){1'b0}}, cmd.window_ms}) begin
              full  <= 1'b1;
              state <= S_MUL0;
            end else begin
              have_old  <= 1'b1;
              old_stamp <= rd_stamp;
              old_count <= rd_count;
              if (step == (RW+1)'(RING_DEPTH - 1)) begin
                state <= S_MUL0;
              end else begin
                step  <= step + 1'b1;
                idx   <= (idx == '0) ? RW'(RING_DEPTH - 1) : idx - 1'b1;
                state <= S_RD;
              end
            end
          end
        end
        S_MUL0: begin
          p0    <= 64'(delta[31:0]) * 64'(MS_Q16);
          span  <= new_stamp - old_stamp;
          if (!full || !have_old || new_stamp <= old_stamp || new_count < old_count)
            state <= S_ACC;
          else state <= S_MUL1;
        end
        S_MUL1: begin
          // High half of the count delta.
          p1 <= 64'(delta[COUNT_W-1:32]) * 64'(MS_Q16);
          state <= S_DIV;
          bitn  <= 7'd0;
        end
        S_DIV: begin
          if (bitn == 7'd0) begin
            quot     <= '0;
            bitn     <= 7'd1;
            dividend <= {p1[31:0] + p0[63:32], p0[31:0], 64'd0};
            rem      <= (STAMP_W+1)'((p1 + {32'd0, p0[63:32]}) >> 32);
            if (((p1 + {32'd0, p0[63:32]}) >> 32) >= 64'(span)) begin
              rate_r <= '1;
              state  <= S_ACC;
            end
          end else begin
            dividend <= dividend << 1;
            if (!trial[STAMP_W]) begin
              rem  <= trial;
              quot <= {quot[62:0], 1'b1};
            end else begin
              rem  <= {rem[STAMP_W-1:0], dividend[127]};
              quot <= {quot[62:0], 1'b0};
            end
            bitn <= bitn + 1'b1;
            if (bitn == 7'd64) begin
              rate_r <= {quot[62:0], ~trial[STAMP_W]};
              state  <= S_ACC;
            end
          end
        end
        S_ACC: begin
          if (cmd.mode == MODE_RATE) begin
            state <= S_OUT;
          end else begin
            total <= sum[RATE_W] ? '1 : sum[RATE_W-1:0];
            if (ch == CW'(CHANNELS - 1) || CHANNELS == 1) begin
              state <= S_OUT;
              rate_r <= sum[RATE_W] ? '1 : sum[RATE_W-1:0];
              if ((sum[RATE_W] ? '1 : sum[RATE_W-1:0]) > highest)
                highest <= sum[RATE_W] ? '1 : sum[RATE_W-1:0];
            end else begin
              ch    <= ch + 1'b1;
              state <= S_CHAN;
            end
          end
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/windowed_rate_meter_top.sv =====
// ---------------------------------------------------------------------------
// windowed_rate_meter_top: sliding window event rate meter
// Records count/stamp samples per channel and reports windowed rates.
// ---------------------------------------------------------------------------
//   channel   dir   beat contents
//   in_ch     in    mode, channel, sample_count, time_ms, window_ms
//   out_ch    out   rate_q16, rate_valid, highest_q16 (modes 1 and 2 only)
//
// A record is written to the RAM as it is popped from the queue. A rate
// query reads, waits on and examines each ring entry that it walks, then
// runs a bit-serial divide; a total query repeats that for every channel.
// The shared single-port sample RAM paces the walk; the divider gives
// one bit per cycle. After reset the RAM is cleared, one entry a cycle,
// over its power-of-two depth (128 by default) before queued beats run.
// The two-entry queue keeps taking input, until full, while a result is stalled.
module windowed_rate_meter_top
  import wrm_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input logic clk,
  input logic rst,
  wrm_in_if.sink    in_ch,
  wrm_out_if.source out_ch
);
  logic q_valid, q_pop;
  cmd_t q_head;

  // Front end: accept and queue commands.
  wrm_front #(.QDEPTH(2)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  // Back end: store samples and compute rates.
  wrm_back #(.CHANNELS(CHANNELS), .RING_DEPTH(RING_DEPTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop),
    .q_head(q_head), .out_ch(out_ch)
  );
endmodule
